// ===== hdl/shcr_pkg.sv =====
// ----------------------------------------------------------------------------
// shcr_pkg: shared types and constants for the sync header frame receiver
// Byte kind codes, register indexes and the per-byte result record.
// ----------------------------------------------------------------------------
package shcr_pkg;

    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH = 2'd1;

    localparam logic [7:0] SYNC_BYTE_RESET    = 8'h53;  // 'S'
    localparam logic [7:0] FRAME_LENGTH_RESET = 8'd106;
    localparam logic [7:0] MIN_FRAME_BYTES    = 8'd5;

    typedef enum logic [1:0] {
        KIND_DISCARD  = 2'd0,
        KIND_HEADER   = 2'd1,
        KIND_BODY     = 2'd2,
        KIND_CHECKSUM = 2'd3
    } byte_kind_t;

    typedef struct packed {
        byte_kind_t  byte_kind;
        logic [7:0]  byte_index;
        logic [7:0]  data_out;
        logic        frame_end;
        logic        frame_good;
        logic [15:0] computed_sum;
    } shcr_result_t;

endpackage

// ===== hdl/shcr_frame_core.sv =====
// ----------------------------------------------------------------------------
// shcr_frame_core: header hunt, byte counting and checksum compare
// Holds the config registers and frame state; forms the result of a byte
// in the same cycle the byte is taken.
// ----------------------------------------------------------------------------
module shcr_frame_core
    import shcr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_wdata,
    input  logic                   byte_take,
    input  logic [7:0]             data_byte,
    output shcr_result_t           result
);

    logic [7:0]  sync_byte_reg,    sync_byte_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic        in_frame_reg,     in_frame_next;
    logic [7:0]  byte_count_reg,   byte_count_next;
    logic [15:0] running_sum_reg,  running_sum_next;
    logic [7:0]  checksum_low_reg, checksum_low_next;

    logic [7:0]  eff_len;
    logic [8:0]  idx_plus2;
    logic [15:0] sum_plus_byte;
    logic        is_sync;

    always_comb begin
        sync_byte_next    = sync_byte_reg;
        frame_length_next = frame_length_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SYNC_BYTE:    sync_byte_next    = cfg_wdata;
                REG_FRAME_LENGTH: frame_length_next = cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Lengths under the minimum saturate up; the 8-bit field tops out at 255.
    assign eff_len       = (frame_length_reg < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES
                                                                : frame_length_reg;
    assign idx_plus2     = {1'b0, byte_count_reg} + 9'd2;
    assign sum_plus_byte = running_sum_reg + {8'd0, data_byte};
    assign is_sync       = (data_byte == sync_byte_reg);

    always_comb begin
        in_frame_next     = in_frame_reg;
        byte_count_next   = byte_count_reg;
        running_sum_next  = running_sum_reg;
        checksum_low_next = checksum_low_reg;

        result.byte_kind    = KIND_DISCARD;
        result.byte_index   = 8'd0;
        result.data_out     = data_byte;
        result.frame_end    = 1'b0;
        result.frame_good   = 1'b0;
        result.computed_sum = 16'd0;

        if (!in_frame_reg) begin
            if (is_sync && byte_count_reg == 8'd0) begin
                running_sum_next    = {8'd0, data_byte};
                byte_count_next     = 8'd1;
                result.byte_kind    = KIND_HEADER;
                result.computed_sum = {8'd0, data_byte};
            end else if (is_sync && byte_count_reg == 8'd1) begin
                running_sum_next    = sum_plus_byte;
                byte_count_next     = 8'd2;
                in_frame_next       = 1'b1;
                result.byte_kind    = KIND_HEADER;
                result.byte_index   = 8'd1;
                result.computed_sum = sum_plus_byte;
            end else begin
                // broken header: the byte is dropped, not retried as a first sync
                byte_count_next  = 8'd0;
                running_sum_next = 16'd0;
            end
        end else begin
            result.byte_index = byte_count_reg;
            if (idx_plus2 < {1'b0, eff_len}) begin
                running_sum_next    = sum_plus_byte;
                byte_count_next     = byte_count_reg + 8'd1;
                result.byte_kind    = KIND_BODY;
                result.computed_sum = sum_plus_byte;
            end else if (idx_plus2 == {1'b0, eff_len}) begin
                checksum_low_next   = data_byte;
                byte_count_next     = byte_count_reg + 8'd1;
                result.byte_kind    = KIND_CHECKSUM;
                result.computed_sum = running_sum_reg;
            end else begin
                // final byte, also taken when the length was lowered mid-frame
                result.byte_kind    = KIND_CHECKSUM;
                result.frame_end    = 1'b1;
                result.frame_good   = (running_sum_reg == {data_byte, checksum_low_reg});
                result.computed_sum = running_sum_reg;
                in_frame_next       = 1'b0;
                byte_count_next     = 8'd0;
                running_sum_next    = 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg    <= SYNC_BYTE_RESET;
            frame_length_reg <= FRAME_LENGTH_RESET;
            in_frame_reg     <= 1'b0;
            byte_count_reg   <= 8'd0;
            running_sum_reg  <= 16'd0;
            checksum_low_reg <= 8'd0;
        end else begin
            sync_byte_reg    <= sync_byte_next;
            frame_length_reg <= frame_length_next;
            if (byte_take) begin
                in_frame_reg     <= in_frame_next;
                byte_count_reg   <= byte_count_next;
                running_sum_reg  <= running_sum_next;
                checksum_low_reg <= checksum_low_next;
            end
        end
    end

    a_frame_count_past_header: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (byte_count_reg >= 8'd2))
        else $error("in frame with byte count below two");

    a_hunt_count_small: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (byte_count_reg <= 8'd1))
        else $error("hunting with byte count above one");

    a_end_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_take && result.frame_end) |=>
            (!in_frame_reg && byte_count_reg == 8'd0 && running_sum_reg == 16'd0))
        else $error("frame end did not return to hunting");

endmodule

// ===== hdl/shcr_out_buf.sv =====
// ----------------------------------------------------------------------------
// shcr_out_buf: result register with a skid stage
// Lets a new request in while the held result waits on m_ready.
// ----------------------------------------------------------------------------
module shcr_out_buf
    import shcr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  shcr_result_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output shcr_result_t out_data
);

    shcr_result_t out_reg;
    shcr_result_t skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         push;
    logic         take;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign take      = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || take) begin
                out_reg       <= in_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output is empty");

    a_push_makes_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> out_valid_reg)
        else $error("accepted request produced no pending result");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && take) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid result not moved to output");

endmodule

// ===== hdl/sync_header_frame_checksum_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// sync_header_frame_checksum_receiver_unit: byte-stream frame receiver
// Hunts for a two-byte sync header, counts a fixed-length frame and checks
// its little-endian 16-bit additive checksum.
// ----------------------------------------------------------------------------
// One request on s_ carries one received byte; every byte produces exactly
// one result on m_, the cycle after it is taken when the output register is
// free (later only while earlier results wait on m_ready), echoing the byte
// with its kind (discard, header, body, checksum), its zero-based position
// in the frame and the running 16-bit wrapping sum. A frame starts with two
// consecutive sync_byte values; a non-sync byte while hunting is dropped and
// restarts the hunt without being retried as a header byte. The sum covers
// every byte except the last two, which carry the checksum low byte first.
// On the last byte m_frame_end is 1 and m_frame_good tells whether the sum
// matched. frame_length below 5 acts as 5. Throughput is one byte per cycle:
// the per-byte update is one counter step, one 16-bit add and one compare,
// and a two-deep result buffer keeps s_ready high unless two results
// wait on m_ready. Write configuration only while no result is pending.
// ----------------------------------------------------------------------------
module sync_header_frame_checksum_receiver_unit
    import shcr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_wdata,

    // received bytes
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,

    // per-byte results
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_byte_kind,
    output logic [7:0]             m_byte_index,
    output logic [7:0]             m_data_out,
    output logic                   m_frame_end,
    output logic                   m_frame_good,
    output logic [15:0]            m_computed_sum
);

    shcr_result_t core_result;
    shcr_result_t out_result;
    logic         byte_take;

    // frame state advances only when a request is actually taken
    assign byte_take = s_valid && s_ready;

    shcr_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .byte_take (byte_take),
        .data_byte (s_data_byte),
        .result    (core_result)
    );

    // result register plus skid slot
    shcr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (core_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_byte_kind    = out_result.byte_kind;
    assign m_byte_index   = out_result.byte_index;
    assign m_data_out     = out_result.data_out;
    assign m_frame_end    = out_result.frame_end;
    assign m_frame_good   = out_result.frame_good;
    assign m_computed_sum = out_result.computed_sum;

endmodule
